@@ hw/rtl/lsrc_pkg.sv @@
// shared constants for the light screen rectangle cull block
package lsrc_pkg;

  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;

  // screen scale factors in unsigned q14.16
  localparam int K_W = 30;
  localparam logic [K_W-1:0] KX = K_W'(SCREEN_WIDTH * 65536);
  localparam logic [K_W-1:0] KY = K_W'(SCREEN_HEIGHT * 65536);

  localparam logic signed [31:0] LIM_X = 32'(SCREEN_WIDTH * 65536);
  localparam logic signed [31:0] LIM_Y = 32'(SCREEN_HEIGHT * 65536);

  localparam int CLIP_W    = 50;
  localparam int MAG_W     = 51;
  localparam int DEN_W     = 51;
  localparam int HI_W      = MAG_W - 32;
  localparam int PH_W      = HI_W + K_W;
  localparam int D_W       = PH_W + 32;
  localparam int TOP_W     = D_W - 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 4;

  localparam int NUM_REGS = 8;

endpackage

@@ hw/rtl/lsrc_div.sv @@
// pipelined scaled divider: floor(num * k / den), saturated to 32 bits
module lsrc_div (
  input  logic                              clk,
  input  logic                              ce,
  input  logic [lsrc_pkg::MAG_W-1:0]        mag_i,
  input  logic                              neg_i,
  input  logic [lsrc_pkg::DEN_W-1:0]        den_i,
  input  logic [lsrc_pkg::K_W-1:0]          k_i,
  output logic signed [31:0]                res_o
);

  logic [lsrc_pkg::PH_W-1:0]      ph_r;
  logic [31+lsrc_pkg::K_W:0]      pl_r;
  logic                           neg1_r;
  logic [lsrc_pkg::DEN_W-1:0]     den1_r;

  logic [lsrc_pkg::D_W-1:0]       d_r;
  logic                           neg2_r;
  logic [lsrc_pkg::DEN_W-1:0]     den2_r;

  logic [lsrc_pkg::DEN_W-1:0]     rem_r [lsrc_pkg::DIV_STEPS+1];
  logic [31:0]                    q_r   [lsrc_pkg::DIV_STEPS+1];
  logic [31:0]                    lo_r  [lsrc_pkg::DIV_STEPS+1];
  logic                           ovf_r [lsrc_pkg::DIV_STEPS+1];
  logic                           neg_r [lsrc_pkg::DIV_STEPS+1];
  logic [lsrc_pkg::DEN_W-1:0]     den_r [lsrc_pkg::DIV_STEPS+1];

  logic [lsrc_pkg::TOP_W-1:0]     d_top;
  logic [32:0]                    qq;
  logic                           rem_nz;
  logic signed [31:0]             res_nxt;
  logic signed [31:0]             res_r;

  // partial products of the 51 bit magnitude
  always_ff @(posedge clk) begin
    if (ce) begin
      ph_r   <= mag_i[lsrc_pkg::MAG_W-1:32] * k_i;
      pl_r   <= mag_i[31:0] * k_i;
      neg1_r <= neg_i;
      den1_r <= den_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_r    <= {ph_r, 32'd0} + lsrc_pkg::D_W'(pl_r);
      neg2_r <= neg1_r;
      den2_r <= den1_r;
    end
  end

  assign d_top = d_r[lsrc_pkg::D_W-1:32];

  // quotient of 2^32 or more saturates, else the top part is the first remainder
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= lsrc_pkg::DEN_W'(d_top);
      q_r[0]   <= '0;
      lo_r[0]  <= d_r[31:0];
      ovf_r[0] <= lsrc_pkg::DEN_W'(d_top) >= den2_r;
      neg_r[0] <= neg2_r;
      den_r[0] <= den2_r;
    end
  end

  for (genvar j = 0; j < lsrc_pkg::DIV_STEPS; j++) begin : g_step
    logic [lsrc_pkg::DEN_W:0] t;
    logic                     ge;
    assign t  = {rem_r[j], lo_r[j][31]};
    assign ge = t >= {1'b0, den_r[j]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j+1] <= ge ? lsrc_pkg::DEN_W'(t - {1'b0, den_r[j]})
                         : lsrc_pkg::DEN_W'(t);
        q_r[j+1]   <= {q_r[j][30:0], ge};
        lo_r[j+1]  <= {lo_r[j][30:0], 1'b0};
        ovf_r[j+1] <= ovf_r[j];
        neg_r[j+1] <= neg_r[j];
        den_r[j+1] <= den_r[j];
      end
    end
  end

  always_comb begin
    rem_nz = rem_r[lsrc_pkg::DIV_STEPS] != '0;
    qq     = {1'b0, q_r[lsrc_pkg::DIV_STEPS]} + {32'd0, rem_nz};
    if (!neg_r[lsrc_pkg::DIV_STEPS]) begin
      if (ovf_r[lsrc_pkg::DIV_STEPS] || q_r[lsrc_pkg::DIV_STEPS][31]) begin
        res_nxt = 32'sh7fffffff;
      end else begin
        res_nxt = $signed(q_r[lsrc_pkg::DIV_STEPS]);
      end
    end else begin
      if (ovf_r[lsrc_pkg::DIV_STEPS] || qq[32] || qq[31]) begin
        res_nxt = 32'sh80000000;
      end else begin
        res_nxt = $signed(32'(33'd0 - qq));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

@@ hw/rtl/light_screen_rect_cull.sv @@
// top level: screen space bounding rectangle of a point light
// a light runs through stages 1 to 5, the divider lanes and stages 6 to 8
// throughput: one light per cycle while in_tready is high; 18 multipliers,
// and 16 divider lanes of one quotient bit per stage set the pipeline depth
// a two entry output buffer keeps input open while one result waits
// reset: synchronous active low rst_n clears valids and the matrix to zero
module light_screen_rect_cull (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, radius, zero pad
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // box_min_x, box_min_y, box_max_x, box_max_y
  output logic [127:0] out_tdata,
  // on_screen
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] mreg_r [lsrc_pkg::NUM_REGS];
  logic signed [31:0] ment [3][4];

  logic ce;
  logic skid_v_r;
  logic [127:0] skid_d_r;
  logic skid_u_r;

  logic signed [31:0] cin [3];
  logic signed [31:0] rad;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [63:0] cm_r [3][3];
  logic signed [63:0] rm_r [3][3];
  logic signed [48:0] t_r  [8][3][3];
  logic signed [lsrc_pkg::CLIP_W-1:0] clip_r [8][3];
  logic signed [lsrc_pkg::CLIP_W:0] numx_r [8];
  logic signed [lsrc_pkg::CLIP_W:0] numy_r [8];
  logic [lsrc_pkg::DEN_W-1:0] den4_r [8];
  logic [7:0] front4_r;
  logic [lsrc_pkg::MAG_W-1:0] magx_r [8];
  logic [lsrc_pkg::MAG_W-1:0] magy_r [8];
  logic [7:0] negx_r, negy_r;
  logic [lsrc_pkg::DEN_W-1:0] den5_r [8];
  logic [7:0] front5_r;

  logic [lsrc_pkg::DIV_LAT-1:0] vd_r;
  logic [7:0] fd_r [lsrc_pkg::DIV_LAT];
  logic signed [31:0] sx [8];
  logic signed [31:0] sy [8];

  logic v6_r, v7_r, v8_r;
  logic signed [31:0] mnx1_r [4], mny1_r [4], mxx1_r [4], mxy1_r [4];
  logic signed [31:0] mnx2_r [2], mny2_r [2], mxx2_r [2], mxy2_r [2];
  logic signed [31:0] mnx3_r, mny3_r, mxx3_r, mxy3_r;
  logic any6_r, any7_r, any8_r;

  logic vis;
  logic [127:0] res_d;

  // matrix registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lsrc_pkg::NUM_REGS; i++) begin
        mreg_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < 8'(lsrc_pkg::NUM_REGS)) begin
      mreg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // rows x, y and w only
  always_comb begin
    int rr;
    logic [2:0] idx;
    for (int i = 0; i < 3; i++) begin
      rr = (i == 2) ? 3 : i;
      for (int j = 0; j < 4; j++) begin
        idx = 3'(rr * 2 + j / 2);
        ment[i][j] = (j % 2 == 1) ? $signed(mreg_r[idx][63:32])
                                  : $signed(mreg_r[idx][31:0]);
      end
    end
  end

  // pipeline advances while the skid entry is free
  assign ce        = !skid_v_r;
  assign in_tready = ce;

  assign cin[0] = $signed(in_tdata[31:0]);
  assign cin[1] = $signed(in_tdata[63:32]);
  assign cin[2] = $signed(in_tdata[95:64]);
  assign rad    = $signed({1'b0, in_tdata[126:96]});

  // stage 1: centre and radius products
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          cm_r[i][a] <= cin[a] * ment[i][a];
          rm_r[i][a] <= rad * ment[i][a];
        end
      end
    end
  end

  // stage 2: floored corner products
  always_ff @(posedge clk) begin
    logic signed [64:0] s;
    if (ce) begin
      for (int n = 0; n < 8; n++) begin
        for (int i = 0; i < 3; i++) begin
          for (int a = 0; a < 3; a++) begin
            s = ((n >> a) % 2 == 1) ? 65'(cm_r[i][a]) + 65'(rm_r[i][a])
                                    : 65'(cm_r[i][a]) - 65'(rm_r[i][a]);
            t_r[n][i][a] <= s[64:16];
          end
        end
      end
    end
  end

  // stage 3: clip coordinates
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int n = 0; n < 8; n++) begin
        for (int i = 0; i < 3; i++) begin
          clip_r[n][i] <= lsrc_pkg::CLIP_W'(ment[i][3])
                        + lsrc_pkg::CLIP_W'(t_r[n][i][0])
                        + lsrc_pkg::CLIP_W'(t_r[n][i][1])
                        + lsrc_pkg::CLIP_W'(t_r[n][i][2]);
        end
      end
    end
  end

  // stage 4: numerators, denominator, front test
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int n = 0; n < 8; n++) begin
        numx_r[n]   <= (lsrc_pkg::CLIP_W+1)'(clip_r[n][0])
                     + (lsrc_pkg::CLIP_W+1)'(clip_r[n][2]);
        numy_r[n]   <= (lsrc_pkg::CLIP_W+1)'(clip_r[n][2])
                     - (lsrc_pkg::CLIP_W+1)'(clip_r[n][1]);
        den4_r[n]   <= lsrc_pkg::DEN_W'({clip_r[n][2], 1'b0});
        front4_r[n] <= clip_r[n][2] > 0;
      end
    end
  end

  // stage 5: sign and magnitude
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int n = 0; n < 8; n++) begin
        negx_r[n] <= numx_r[n][lsrc_pkg::CLIP_W];
        negy_r[n] <= numy_r[n][lsrc_pkg::CLIP_W];
        magx_r[n] <= numx_r[n][lsrc_pkg::CLIP_W] ? lsrc_pkg::MAG_W'(-numx_r[n])
                                                 : lsrc_pkg::MAG_W'(numx_r[n]);
        magy_r[n] <= numy_r[n][lsrc_pkg::CLIP_W] ? lsrc_pkg::MAG_W'(-numy_r[n])
                                                 : lsrc_pkg::MAG_W'(numy_r[n]);
        den5_r[n] <= den4_r[n];
      end
      front5_r <= front4_r;
    end
  end

  for (genvar n = 0; n < 8; n++) begin : g_lane
    lsrc_div u_div_x (
      .clk   (clk),
      .ce    (ce),
      .mag_i (magx_r[n]),
      .neg_i (negx_r[n]),
      .den_i (den5_r[n]),
      .k_i   (lsrc_pkg::KX),
      .res_o (sx[n])
    );
    lsrc_div u_div_y (
      .clk   (clk),
      .ce    (ce),
      .mag_i (magy_r[n]),
      .neg_i (negy_r[n]),
      .den_i (den5_r[n]),
      .k_i   (lsrc_pkg::KY),
      .res_o (sy[n])
    );
  end

  // front flags follow the divider lanes
  always_ff @(posedge clk) begin
    if (ce) begin
      fd_r[0] <= front5_r;
      for (int i = 1; i < lsrc_pkg::DIV_LAT; i++) begin
        fd_r[i] <= fd_r[i-1];
      end
    end
  end

  // stages 6 to 8: min and max tree, corners behind the eye drop out
  always_ff @(posedge clk) begin
    logic signed [31:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic f0, f1;
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        f0  = fd_r[lsrc_pkg::DIV_LAT-1][2*i];
        f1  = fd_r[lsrc_pkg::DIV_LAT-1][2*i+1];
        ax0 = f0 ? sx[2*i]   : 32'sh7fffffff;
        ax1 = f1 ? sx[2*i+1] : 32'sh7fffffff;
        ay0 = f0 ? sy[2*i]   : 32'sh7fffffff;
        ay1 = f1 ? sy[2*i+1] : 32'sh7fffffff;
        bx0 = f0 ? sx[2*i]   : 32'sh80000000;
        bx1 = f1 ? sx[2*i+1] : 32'sh80000000;
        by0 = f0 ? sy[2*i]   : 32'sh80000000;
        by1 = f1 ? sy[2*i+1] : 32'sh80000000;
        mnx1_r[i] <= (ax1 < ax0) ? ax1 : ax0;
        mny1_r[i] <= (ay1 < ay0) ? ay1 : ay0;
        mxx1_r[i] <= (bx1 > bx0) ? bx1 : bx0;
        mxy1_r[i] <= (by1 > by0) ? by1 : by0;
      end
      any6_r <= |fd_r[lsrc_pkg::DIV_LAT-1];
      for (int i = 0; i < 2; i++) begin
        mnx2_r[i] <= (mnx1_r[2*i+1] < mnx1_r[2*i]) ? mnx1_r[2*i+1] : mnx1_r[2*i];
        mny2_r[i] <= (mny1_r[2*i+1] < mny1_r[2*i]) ? mny1_r[2*i+1] : mny1_r[2*i];
        mxx2_r[i] <= (mxx1_r[2*i+1] > mxx1_r[2*i]) ? mxx1_r[2*i+1] : mxx1_r[2*i];
        mxy2_r[i] <= (mxy1_r[2*i+1] > mxy1_r[2*i]) ? mxy1_r[2*i+1] : mxy1_r[2*i];
      end
      any7_r <= any6_r;
      mnx3_r <= (mnx2_r[1] < mnx2_r[0]) ? mnx2_r[1] : mnx2_r[0];
      mny3_r <= (mny2_r[1] < mny2_r[0]) ? mny2_r[1] : mny2_r[0];
      mxx3_r <= (mxx2_r[1] > mxx2_r[0]) ? mxx2_r[1] : mxx2_r[0];
      mxy3_r <= (mxy2_r[1] > mxy2_r[0]) ? mxy2_r[1] : mxy2_r[0];
      any8_r <= any7_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vd_r <= '0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vd_r <= {vd_r[lsrc_pkg::DIV_LAT-2:0], v5_r};
      v6_r <= vd_r[lsrc_pkg::DIV_LAT-1];
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // visibility test and culled result
  assign vis = any8_r && !mxx3_r[31] && !mxy3_r[31]
            && mnx3_r <= lsrc_pkg::LIM_X && mny3_r <= lsrc_pkg::LIM_Y;

  assign res_d = vis ? {mxy3_r, mxx3_r, mny3_r, mnx3_r}
                     : {32'hffff0000, 32'hffff0000, 32'h00010000, 32'h00010000};

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      skid_v_r   <= 1'b0;
    end else if (!out_tvalid || out_tready) begin
      if (skid_v_r) begin
        out_tvalid <= 1'b1;
        skid_v_r   <= 1'b0;
      end else begin
        out_tvalid <= v8_r;
      end
    end else if (v8_r && ce) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_tvalid || out_tready) begin
      if (skid_v_r) begin
        out_tdata <= skid_d_r;
        out_tuser <= skid_u_r;
      end else begin
        out_tdata <= res_d;
        out_tuser <= vis;
      end
    end else if (v8_r && ce) begin
      skid_d_r <= res_d;
      skid_u_r <= vis;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for light_screen_rect_cull: tables and random lights checked against a predictor
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
  } light_t;

  typedef struct {
    logic signed [31:0] mnx;
    logic signed [31:0] mny;
    logic signed [31:0] mxx;
    logic signed [31:0] mxy;
    logic               vis;
  } rect_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  logic [63:0] matrix [lsrc_pkg::NUM_REGS];
  rect_t       rect_q [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          quiet_cycles = 0;

  light_t culled_rows [6];
  light_t directed_rows [10];

  always #5 clk = ~clk;

  light_screen_rect_cull u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic logic signed [31:0] mentry(int row, int col);
    logic [63:0] r;
    r = matrix[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic signed [31:0] pixel_floor(logic signed [127:0] num, int k,
                                                     logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] rm;
    bit           neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q   = (mag * 128'(k)) / den;
    rm  = (mag * 128'(k)) % den;
    if (!neg) return (q > 128'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
    if (rm != 0) q = q + 1;
    if (q >= 128'h8000_0000) return 32'sh8000_0000;
    return -q[31:0];
  endfunction

  function automatic rect_t project_light(light_t l);
    logic signed [127:0] c [3];
    logic signed [127:0] p;
    logic signed [127:0] clip [4];
    logic signed [127:0] rr;
    logic signed [31:0]  sx;
    logic signed [31:0]  sy;
    rect_t               b;
    bit                  any;
    c[0] = l.cx;
    c[1] = l.cy;
    c[2] = l.cz;
    rr   = {97'd0, l.rad};
    any  = 1'b0;
    b.mnx = 32'sh7fff_ffff;
    b.mny = 32'sh7fff_ffff;
    b.mxx = 32'sh8000_0000;
    b.mxy = 32'sh8000_0000;
    for (int n = 0; n < 8; n++) begin
      for (int row = 0; row < 4; row++) begin
        clip[row] = mentry(row, 3);
        for (int a = 0; a < 3; a++) begin
          p = ((n >> a) & 1) ? c[a] + rr : c[a] - rr;
          clip[row] = clip[row] + ((p * mentry(row, a)) >>> 16);
        end
      end
      if (clip[3] > 0) begin
        any = 1'b1;
        sx = pixel_floor(clip[0] + clip[3], lsrc_pkg::SCREEN_WIDTH * 65536, clip[3] * 2);
        sy = pixel_floor(clip[3] - clip[1], lsrc_pkg::SCREEN_HEIGHT * 65536, clip[3] * 2);
        if (sx < b.mnx) b.mnx = sx;
        if (sy < b.mny) b.mny = sy;
        if (sx > b.mxx) b.mxx = sx;
        if (sy > b.mxy) b.mxy = sy;
      end
    end
    b.vis = any && b.mxx >= 0 && b.mxy >= 0 && b.mnx <= lsrc_pkg::LIM_X
            && b.mny <= lsrc_pkg::LIM_Y;
    if (!b.vis) begin
      b.mnx = ONE;
      b.mny = ONE;
      b.mxx = -ONE;
      b.mxy = -ONE;
    end
    return b;
  endfunction

  task automatic send_light(light_t l, bit typed, rect_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, l.rad, l.cz, l.cy, l.cx};
    do @(posedge clk); while (!in_tready);
    rect_q.push_back(typed ? want : project_light(l));
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < lsrc_pkg::NUM_REGS) matrix[idx] = val;
  endtask

  task automatic load_matrix(logic [31:0] e [16]);
    for (int i = 0; i < lsrc_pkg::NUM_REGS; i++)
      write_reg(8'(i), {e[i * 2 + 1], e[i * 2]});
    write_reg(8'(lsrc_pkg::NUM_REGS + $urandom_range(247)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // perspective style matrix with optional jitter, w taken from z
  task automatic load_perspective(bit jitter);
    logic [31:0] e [16];
    for (int i = 0; i < 16; i++) e[i] = '0;
    e[0]  = 32'h0080_0000 + $urandom_range(32'h0180_0000);
    e[5]  = 32'h0080_0000 + $urandom_range(32'h0180_0000);
    e[10] = 32'h0100_0000;
    e[11] = -32'h0040_0000;
    e[14] = 32'h0100_0000;
    if (jitter) begin
      for (int i = 0; i < 16; i++) e[i] = e[i] + $urandom_range(32'h0020_0000) - 32'h0010_0000;
    end
    load_matrix(e);
  endtask

  function automatic light_t shaped_light();
    light_t l;
    int     zi;
    zi    = $urandom_range(1, 200);
    l.cz  = $urandom_range(2, 60) * 65536 + $urandom_range(65535);
    if ($urandom_range(9) == 0) l.cz = -l.cz;
    l.cx  = $signed($urandom_range(2 * zi * 65536)) - zi * 65536;
    l.cy  = $signed($urandom_range(2 * zi * 65536)) - zi * 65536;
    l.rad = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(8 * 65536));
    return l;
  endfunction

  function automatic light_t noise_light();
    light_t l;
    l.cx  = $urandom;
    l.cy  = $urandom;
    l.cz  = $urandom;
    l.rad = 31'($urandom);
    return l;
  endfunction

  task automatic random_lights(int count, int idle, int stall, bit shaped);
    rect_t dummy;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    dummy = '{default: '0};
    for (int i = 0; i < count; i++) begin
      if (shaped && $urandom_range(99) < 80) send_light(shaped_light(), 1'b0, dummy);
      else send_light(noise_light(), 1'b0, dummy);
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    rect_t got;
    rect_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mnx = out_tdata[31:0];
      got.mny = out_tdata[63:32];
      got.mxx = out_tdata[95:64];
      got.mxy = out_tdata[127:96];
      got.vis = out_tuser;
      if (rect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", out_tdata, out_tuser);
      end else begin
        want = rect_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                     want.mnx, want.mny, want.mxx, want.mxy, want.vis,
                     got.mnx, got.mny, got.mxx, got.mxy, got.vis);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rect_t       culled;
    rect_t       dummy;
    logic [31:0] e [16];
    culled = '{mnx: ONE, mny: ONE, mxx: -ONE, mxy: -ONE, vis: 1'b0};
    dummy  = '{default: '0};
    for (int i = 0; i < lsrc_pkg::NUM_REGS; i++) matrix[i] = '0;

    culled_rows[0] = '{32'sh0, 32'sh0, 32'sh0, 31'h0};
    culled_rows[1] = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff};
    culled_rows[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff};
    culled_rows[3] = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0005_0000, 31'h0001_0000};
    culled_rows[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 31'h0};
    culled_rows[5] = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 31'h2aaa_aaaa};

    directed_rows[0] = '{32'sh0, 32'sh0, 32'sh000a_0000, 31'h0001_0000};
    directed_rows[1] = '{32'sh0, 32'sh0, -32'sh000a_0000, 31'h0001_0000};
    directed_rows[2] = '{32'sh0, 32'sh0, 32'sh0000_8000, 31'h0002_0000};
    directed_rows[3] = '{-32'sh0064_0000, 32'sh0, 32'sh000a_0000, 31'h0001_0000};
    directed_rows[4] = '{32'sh0064_0000, 32'sh0064_0000, 32'sh000a_0000, 31'h0001_0000};
    directed_rows[5] = '{32'sh0, 32'sh0, 32'sh0002_0000, 31'h7fff_ffff};
    directed_rows[6] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 31'h0};
    directed_rows[7] = '{32'sh0, 32'sh0, 32'sh0001_0000, 31'h0};
    directed_rows[8] = '{32'sh0008_0000, -32'sh0004_0000, 32'sh0008_0000, 31'h0000_0001};
    directed_rows[9] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix culls everything
    foreach (culled_rows[i]) send_light(culled_rows[i], 1'b1, culled);
    drain();

    load_perspective(1'b0);
    foreach (directed_rows[i]) send_light(directed_rows[i], 1'b0, dummy);
    drain();

    // extreme matrices
    for (int i = 0; i < 16; i++) e[i] = 32'h7fff_ffff;
    load_matrix(e);
    random_lights(60, 0, 0, 1'b0);
    drain();
    for (int i = 0; i < 16; i++) e[i] = 32'h8000_0000;
    load_matrix(e);
    random_lights(60, 0, 0, 1'b0);
    drain();
    for (int i = 0; i < 16; i++) e[i] = $urandom;
    load_matrix(e);
    random_lights(60, 33, 33, 1'b0);
    drain();

    load_perspective(1'b1);
    random_lights(200, 0, 0, 1'b1);
    drain();
    load_perspective(1'b1);
    random_lights(200, 70, 0, 1'b1);
    drain();
    load_perspective(1'b0);
    random_lights(200, 0, 70, 1'b1);
    drain();

    // long receiver hold while the sender keeps offering
    load_perspective(1'b1);
    hold_req = 1'b1;
    random_lights(150, 0, 0, 1'b1);
    in_tvalid <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
    random_lights(150, 33, 33, 1'b1);
    drain();

    if (mismatches == 0 && rect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lsrc_pkg.sv
hw/rtl/lsrc_div.sv
hw/rtl/light_screen_rect_cull.sv
tb/tb.sv
